// ===== hdl/xmpcu_pkg.sv =====
`default_nettype none

package xmpcu_pkg;

  // Pattern limits: row counts above MAX_ROWS are clamped.
  localparam int unsigned MAX_ROWS     = 1024;
  localparam int unsigned MAX_CHANNELS = 127;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned INST_W    = 8;
  localparam int unsigned VKIND_W   = 4;
  localparam int unsigned VVAL_W    = 7;
  localparam int unsigned ROW_W     = 10;
  localparam int unsigned CHAN_W    = 7;
  localparam int unsigned ROWCFG_W  = 11;
  localparam int unsigned MASK_W    = 5;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned OUT_USER_W = 5;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 11;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_ROW_COUNT     = 1'b1
  } cfg_index_t;

  // Byte position inside a packed cell, one-hot.
  typedef enum logic [5:0] {
    PH_HEAD  = 6'b000001,
    PH_NOTE  = 6'b000010,
    PH_INST  = 6'b000100,
    PH_VOL   = 6'b001000,
    PH_EFF   = 6'b010000,
    PH_PARAM = 6'b100000
  } phase_t;

  localparam logic [BYTE_W-1:0]  PACK_FLAG_BIT = 8'h80;
  localparam logic [BYTE_W-1:0]  RAW_KEY_OFF   = 8'd97;
  localparam logic [BYTE_W-1:0]  RAW_NOTE_MAX  = 8'd96;
  localparam logic [NOTE_W-1:0]  NOTE_OFFSET   = 7'd12;
  localparam logic [NOTE_W-1:0]  NOTE_KEY_OFF  = 7'd109;
  localparam logic [NOTE_W-1:0]  NOTE_BLANK    = 7'd0;
  localparam logic [BYTE_W-1:0]  INST_NONE_RAW = 8'hFF;
  localparam logic [BYTE_W-1:0]  VOL_LOW       = 8'h10;
  localparam logic [BYTE_W-1:0]  VOL_HIGH      = 8'h50;
  localparam logic [BYTE_W-1:0]  VOL_CMD_BASE  = 8'h60;
  localparam logic [MASK_W-1:0]  MASK_ALL_BUT_NOTE = 5'b11110;

  // Volume column kinds.
  localparam logic [VKIND_W-1:0] VK_NONE    = 4'd0;
  localparam logic [VKIND_W-1:0] VK_VOLUME  = 4'd1;
  localparam logic [VKIND_W-1:0] VK_PANNING = 4'd8;
  // High nibble of a command volume byte maps to kind = nibble - 4.
  localparam logic [3:0]         VK_NIBBLE_OFFSET = 4'd4;

  typedef struct packed {
    logic [NOTE_W-1:0]  note;
    logic [INST_W-1:0]  instrument;
    logic [VKIND_W-1:0] volume_kind;
    logic [VVAL_W-1:0]  volume_value;
    logic [BYTE_W-1:0]  effect_code;
    logic [BYTE_W-1:0]  effect_param;
    logic               has_effect;
    logic [ROW_W-1:0]   row_index;
    logic [CHAN_W-1:0]  channel_index;
    logic               last_cell;
  } cell_t;

  function automatic logic [NOTE_W-1:0] decode_note(input logic [BYTE_W-1:0] raw);
    logic [NOTE_W-1:0] res;
    if (raw == RAW_KEY_OFF) begin
      res = NOTE_KEY_OFF;
    end else if (raw != '0 && raw <= RAW_NOTE_MAX) begin
      res = raw[NOTE_W-1:0] + NOTE_OFFSET;
    end else begin
      res = NOTE_BLANK;
    end
    return res;
  endfunction

  // Panning nibble rescaled to 0..64 as (v*64+8)/15.
  function automatic logic [VVAL_W-1:0] pan_scale(input logic [3:0] v);
    logic [VVAL_W-1:0] res;
    unique case (v)
      4'd0:  res = 7'd0;
      4'd1:  res = 7'd4;
      4'd2:  res = 7'd9;
      4'd3:  res = 7'd13;
      4'd4:  res = 7'd17;
      4'd5:  res = 7'd21;
      4'd6:  res = 7'd26;
      4'd7:  res = 7'd30;
      4'd8:  res = 7'd34;
      4'd9:  res = 7'd38;
      4'd10: res = 7'd43;
      4'd11: res = 7'd47;
      4'd12: res = 7'd51;
      4'd13: res = 7'd56;
      4'd14: res = 7'd60;
      4'd15: res = 7'd64;
      default: res = 7'd0;
    endcase
    return res;
  endfunction

  // First field position at or after 'from' (1 = note .. 5 = parameter)
  // whose bit is set in the mask; PH_HEAD when none remains.
  function automatic phase_t next_phase(input logic [MASK_W-1:0] mask,
                                        input logic [2:0] from);
    phase_t res;
    res = PH_HEAD;
    for (int i = MASK_W - 1; i >= 0; i--) begin
      if (mask[i] && (3'(i + 1) >= from)) begin
        res = phase_t'(6'(1) << (i + 1));
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/xm_pattern_cell_unpacker.sv =====
// A decoded cell is registered onto the result channel in the cycle after the
// transaction that carries the last byte of that cell.
// Throughput: one data byte per cycle; the result register refills in the
// same cycle it drains, so back-pressure only stalls when a cell waits untaken.
// Reset (synchronous, rst_n low): expecting a cell's first byte, row and
// channel counters at zero, channel_count 4, row_count 64, no result pending.
`default_nettype none

module xm_pattern_cell_unpacker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // in_tdata: data_byte [7:0]
  input  wire logic [xmpcu_pkg::BYTE_W-1:0]        in_tdata,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // out_tdata: note [6:0], instrument [14:7], volume_value [21:15],
  // effect_code [29:22], effect_param [37:30], row_index [47:38],
  // channel_index [54:48], zero [55]
  output logic [xmpcu_pkg::OUT_DATA_W-1:0]         out_tdata,
  // out_tuser: volume_kind [3:0], has_effect [4]
  output logic [xmpcu_pkg::OUT_USER_W-1:0]         out_tuser,
  output logic                                     out_tlast,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [xmpcu_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [xmpcu_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [xmpcu_pkg::CHAN_W-1:0]   ch_count_r;
  logic [xmpcu_pkg::ROWCFG_W-1:0] row_count_r;

  xmpcu_pkg::phase_t              phase_r, phase_nxt;
  logic [xmpcu_pkg::MASK_W-1:0]   mask_r, mask_nxt;
  logic [xmpcu_pkg::NOTE_W-1:0]   note_r, note_nxt;
  logic [xmpcu_pkg::INST_W-1:0]   inst_r, inst_nxt;
  logic [xmpcu_pkg::BYTE_W-1:0]   vol_r, vol_nxt;
  logic [xmpcu_pkg::BYTE_W-1:0]   eff_r, eff_nxt;
  logic [xmpcu_pkg::BYTE_W-1:0]   param;
  logic [xmpcu_pkg::ROW_W-1:0]    row_cnt_r, row_cnt_nxt;
  logic [xmpcu_pkg::CHAN_W-1:0]   ch_cnt_r, ch_cnt_nxt;

  xmpcu_pkg::cell_t               cell_r, cell_nxt;
  logic                           out_valid_r, out_valid_nxt;

  logic                           in_accept;
  logic                           emit;
  logic [xmpcu_pkg::VKIND_W-1:0]  vkind;
  logic [xmpcu_pkg::VVAL_W-1:0]   vval;
  logic [xmpcu_pkg::CHAN_W-1:0]   chs_eff;
  logic [xmpcu_pkg::ROWCFG_W-1:0] rows_eff;
  logic                           row_end;
  logic                           last;

  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // Field collection: apply this byte to the held cell and find the next field.
  always_comb begin
    phase_nxt = phase_r;
    mask_nxt  = mask_r;
    note_nxt  = note_r;
    inst_nxt  = inst_r;
    vol_nxt   = vol_r;
    eff_nxt   = eff_r;
    param     = '0;
    unique case (phase_r)
      xmpcu_pkg::PH_HEAD: begin
        note_nxt = '0;
        inst_nxt = '0;
        vol_nxt  = '0;
        eff_nxt  = '0;
        if ((in_tdata & xmpcu_pkg::PACK_FLAG_BIT) != '0) begin
          mask_nxt  = in_tdata[xmpcu_pkg::MASK_W-1:0];
          phase_nxt = xmpcu_pkg::next_phase(in_tdata[xmpcu_pkg::MASK_W-1:0], 3'd1);
        end else begin
          // A plain first byte is the note, with all other fields following.
          note_nxt  = xmpcu_pkg::decode_note(in_tdata);
          mask_nxt  = xmpcu_pkg::MASK_ALL_BUT_NOTE;
          phase_nxt = xmpcu_pkg::PH_INST;
        end
      end
      xmpcu_pkg::PH_NOTE: begin
        note_nxt  = xmpcu_pkg::decode_note(in_tdata);
        phase_nxt = xmpcu_pkg::next_phase(mask_r, 3'd2);
      end
      xmpcu_pkg::PH_INST: begin
        inst_nxt  = (in_tdata == xmpcu_pkg::INST_NONE_RAW) ? '0 : in_tdata;
        phase_nxt = xmpcu_pkg::next_phase(mask_r, 3'd3);
      end
      xmpcu_pkg::PH_VOL: begin
        vol_nxt   = in_tdata;
        phase_nxt = xmpcu_pkg::next_phase(mask_r, 3'd4);
      end
      xmpcu_pkg::PH_EFF: begin
        eff_nxt   = in_tdata;
        phase_nxt = xmpcu_pkg::next_phase(mask_r, 3'd5);
      end
      xmpcu_pkg::PH_PARAM: begin
        param     = in_tdata;
        phase_nxt = xmpcu_pkg::PH_HEAD;
      end
      default: begin
        phase_nxt = xmpcu_pkg::PH_HEAD;
      end
    endcase
  end

  // The cell is complete whenever the next expected byte is a first byte.
  assign emit = (phase_nxt == xmpcu_pkg::PH_HEAD);

  always_comb begin
    vkind = xmpcu_pkg::VK_NONE;
    vval  = '0;
    if (vol_nxt >= xmpcu_pkg::VOL_LOW && vol_nxt <= xmpcu_pkg::VOL_HIGH) begin
      vkind = xmpcu_pkg::VK_VOLUME;
      vval  = xmpcu_pkg::VVAL_W'(vol_nxt - xmpcu_pkg::VOL_LOW);
    end else if (vol_nxt >= xmpcu_pkg::VOL_CMD_BASE) begin
      vkind = vol_nxt[7:4] - xmpcu_pkg::VK_NIBBLE_OFFSET;
      vval  = {3'b000, vol_nxt[3:0]};
      if (vkind == xmpcu_pkg::VK_PANNING) begin
        vval = xmpcu_pkg::pan_scale(vol_nxt[3:0]);
      end
    end
  end

  // Position tracking. A counter left beyond its limit by a register change
  // counts as sitting at the limit.
  always_comb begin
    chs_eff  = (ch_count_r == '0) ? xmpcu_pkg::CHAN_W'(1) : ch_count_r;
    if (row_count_r == '0) begin
      rows_eff = xmpcu_pkg::ROWCFG_W'(1);
    end else if (row_count_r > xmpcu_pkg::ROWCFG_W'(xmpcu_pkg::MAX_ROWS)) begin
      rows_eff = xmpcu_pkg::ROWCFG_W'(xmpcu_pkg::MAX_ROWS);
    end else begin
      rows_eff = row_count_r;
    end
    row_end = (ch_cnt_r >= chs_eff - xmpcu_pkg::CHAN_W'(1));
    last    = row_end &&
              ({1'b0, row_cnt_r} >= rows_eff - xmpcu_pkg::ROWCFG_W'(1));
    if (last) begin
      row_cnt_nxt = '0;
      ch_cnt_nxt  = '0;
    end else if (row_end) begin
      row_cnt_nxt = row_cnt_r + xmpcu_pkg::ROW_W'(1);
      ch_cnt_nxt  = '0;
    end else begin
      row_cnt_nxt = row_cnt_r;
      ch_cnt_nxt  = ch_cnt_r + xmpcu_pkg::CHAN_W'(1);
    end
  end

  always_comb begin
    cell_nxt.note          = note_nxt;
    cell_nxt.instrument    = inst_nxt;
    cell_nxt.volume_kind   = vkind;
    cell_nxt.volume_value  = vval;
    cell_nxt.effect_code   = eff_nxt;
    cell_nxt.effect_param  = param;
    cell_nxt.has_effect    = (eff_nxt | param) != '0;
    cell_nxt.row_index     = row_cnt_r;
    cell_nxt.channel_index = ch_cnt_r;
    cell_nxt.last_cell     = last;
  end

  always_comb begin
    if (in_accept && emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ch_count_r  <= 7'd4;
      row_count_r <= 11'd64;
      phase_r     <= xmpcu_pkg::PH_HEAD;
      mask_r      <= '0;
      row_cnt_r   <= '0;
      ch_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (xmpcu_pkg::cfg_index_t'(cfg_index))
          xmpcu_pkg::CFG_CHANNEL_COUNT: ch_count_r  <= cfg_data[xmpcu_pkg::CHAN_W-1:0];
          xmpcu_pkg::CFG_ROW_COUNT:     row_count_r <= cfg_data;
          default: ;
        endcase
      end
      if (in_accept) begin
        phase_r <= phase_nxt;
        mask_r  <= mask_nxt;
        if (emit) begin
          row_cnt_r <= row_cnt_nxt;
          ch_cnt_r  <= ch_cnt_nxt;
        end
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      note_r <= note_nxt;
      inst_r <= inst_nxt;
      vol_r  <= vol_nxt;
      eff_r  <= eff_nxt;
      if (emit) begin
        cell_r <= cell_nxt;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = cell_r.last_cell;
  assign out_tuser  = {cell_r.has_effect, cell_r.volume_kind};
  assign out_tdata  = {1'b0,
                       cell_r.channel_index,
                       cell_r.row_index,
                       cell_r.effect_param,
                       cell_r.effect_code,
                       cell_r.volume_value,
                       cell_r.instrument,
                       cell_r.note};

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import xmpcu_pkg::*;

  // Byte positions inside a packed cell while it is being collected.
  localparam int SLOT_HEAD  = 0;
  localparam int SLOT_NOTE  = 1;
  localparam int SLOT_INST  = 2;
  localparam int SLOT_VOL   = 3;
  localparam int SLOT_EFF   = 4;
  localparam int SLOT_PARAM = 5;

  // Kind of a command volume byte 0x60..0x6F; higher nibbles count up from here.
  localparam int VK_FIRST_CMD = 2;
  localparam int HOLD_CYCLES  = 250;

  logic                  clk;
  logic                  rst_n;
  logic [BYTE_W-1:0]     in_tdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  typedef struct {
    logic [7:0] data;
    bit         typed;
    cell_t      want_cell;
  } step_row_t;

  // Model of the decoder: register settings, cell being collected, position.
  logic [6:0]  chan_setting;
  logic [10:0] row_setting;
  int          slot;
  logic [4:0]  pending_mask;
  logic [6:0]  cur_note;
  logic [7:0]  cur_inst;
  logic [7:0]  cur_vol;
  logic [7:0]  cur_eff;
  logic [9:0]  row_pos;
  logic [6:0]  chan_pos;

  cell_t       cells_due[$];
  step_row_t   steps[$];
  int          mismatches;
  int          bytes_sent;
  int          burst_left;
  bit          tx_steady;
  bit          hold_req;

  xm_pattern_cell_unpacker i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [6:0] raw_to_note(input logic [7:0] raw);
    if (raw == RAW_KEY_OFF) return NOTE_KEY_OFF;
    if (raw >= 8'd1 && raw <= RAW_NOTE_MAX) return raw[6:0] + NOTE_OFFSET;
    return NOTE_BLANK;
  endfunction

  function automatic int first_field(input logic [4:0] mask, input int from);
    for (int p = from; p <= SLOT_PARAM; p++) begin
      if (mask[p-1]) return p;
    end
    return SLOT_HEAD;
  endfunction

  // Builds the decoded cell from what has been collected and steps the position.
  function automatic cell_t close_cell(input logic [7:0] param);
    cell_t c;
    int    chs;
    int    rows;
    int    kind;
    int    val;
    bit    row_end;
    bit    last_c;
    chs = (chan_setting == 0) ? 1 : int'(chan_setting);
    if (chs > MAX_CHANNELS) chs = MAX_CHANNELS;
    rows = (row_setting == 0) ? 1 : int'(row_setting);
    if (rows > MAX_ROWS) rows = MAX_ROWS;
    kind = VK_NONE;
    val = 0;
    if (cur_vol >= VOL_LOW && cur_vol <= VOL_HIGH) begin
      kind = VK_VOLUME;
      val = cur_vol - VOL_LOW;
    end else if (cur_vol >= VOL_CMD_BASE) begin
      kind = VK_FIRST_CMD + ((cur_vol - VOL_CMD_BASE) >> 4);
      val = cur_vol[3:0];
      if (kind == VK_PANNING) val = (val * 64 + 8) / 15;
    end
    row_end = chan_pos >= chs - 1;
    last_c = row_end && (row_pos >= rows - 1);
    c.note = cur_note;
    c.instrument = cur_inst;
    c.volume_kind = kind[3:0];
    c.volume_value = val[6:0];
    c.effect_code = cur_eff;
    c.effect_param = param;
    c.has_effect = (cur_eff | param) != 8'd0;
    c.row_index = row_pos;
    c.channel_index = chan_pos;
    c.last_cell = last_c;
    if (last_c) begin
      row_pos = '0;
      chan_pos = '0;
    end else if (row_end) begin
      chan_pos = '0;
      row_pos = row_pos + 10'd1;
    end else begin
      chan_pos = chan_pos + 7'd1;
    end
    slot = SLOT_HEAD;
    return c;
  endfunction

  // Takes one accepted byte; returns 1 when it completes a cell.
  function automatic bit absorb_byte(input logic [7:0] b, output cell_t c);
    c = '0;
    if (slot == SLOT_HEAD) begin
      cur_note = '0;
      cur_inst = '0;
      cur_vol = '0;
      cur_eff = '0;
      if (b[7]) begin
        pending_mask = b[4:0];
        slot = first_field(pending_mask, SLOT_NOTE);
      end else begin
        cur_note = raw_to_note(b);
        pending_mask = MASK_ALL_BUT_NOTE;
        slot = SLOT_INST;
      end
      if (slot == SLOT_HEAD) begin
        c = close_cell(8'd0);
        return 1'b1;
      end
      return 1'b0;
    end
    case (slot)
      SLOT_NOTE: cur_note = raw_to_note(b);
      SLOT_INST: cur_inst = (b == INST_NONE_RAW) ? 8'd0 : b;
      SLOT_VOL:  cur_vol = b;
      SLOT_EFF:  cur_eff = b;
      default: begin
        c = close_cell(b);
        return 1'b1;
      end
    endcase
    slot = first_field(pending_mask, slot + 1);
    if (slot == SLOT_HEAD) begin
      c = close_cell(8'd0);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic cell_t cell_of(input int note, input int inst, input int vk, input int vv,
                                    input int eff, input int par, input int has, input int row,
                                    input int chan, input int last_c);
    cell_t c;
    c.note = note[6:0];
    c.instrument = inst[7:0];
    c.volume_kind = vk[3:0];
    c.volume_value = vv[6:0];
    c.effect_code = eff[7:0];
    c.effect_param = par[7:0];
    c.has_effect = has[0];
    c.row_index = row[9:0];
    c.channel_index = chan[6:0];
    c.last_cell = last_c[0];
    return c;
  endfunction

  function automatic void queue_step(input logic [7:0] data, input bit typed,
                                     input cell_t want_cell);
    step_row_t r;
    r.data = data;
    r.typed = typed;
    r.want_cell = want_cell;
    steps.insert(steps.size(), r);
  endfunction

  // Field byte for a given position, leaning toward the decoding boundaries.
  function automatic logic [7:0] pick_field(input int s);
    logic [7:0] r;
    int         sel;
    r = 8'($urandom_range(0, 255));
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      case (s)
        SLOT_NOTE: begin
          case (sel)
            0: r = 8'd0;
            1: r = RAW_KEY_OFF;
            2: r = 8'($urandom_range(1, 96));
            default: r = 8'($urandom_range(98, 255));
          endcase
        end
        SLOT_INST: r = (sel < 2) ? INST_NONE_RAW : 8'd0;
        SLOT_VOL: begin
          case (sel)
            0: r = 8'($urandom_range(VOL_LOW, VOL_HIGH));
            1: r = {4'hC, 4'($urandom_range(0, 15))};
            2: r = 8'($urandom_range(0, 15));
            default: r = 8'($urandom_range(8'h51, 8'h5F));
          endcase
        end
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

  function automatic int next_gap();
    if (tx_steady) return 0;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(1, 24);
    return $urandom_range(1, 5);
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Offers one byte and updates the model once the transaction completes.
  task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                           input cell_t typed_cell = '0);
    int    gap;
    bit    emitted;
    cell_t predicted;
    @(negedge clk);
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata <= b;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    bytes_sent++;
    emitted = absorb_byte(b, predicted);
    if (emitted || typed) cells_due.insert(cells_due.size(), typed ? typed_cell : predicted);
  endtask

  task automatic send_random_cell();
    int         pick;
    logic [7:0] head;
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      // Stray byte: throws the cell framing off until the stream realigns.
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 26) begin
      head = pick_field(SLOT_NOTE);
      head[7] = 1'b0;
      send_byte(head);
      for (int s = SLOT_INST; s <= SLOT_PARAM; s++) send_byte(pick_field(s));
    end else begin
      head = 8'($urandom_range(128, 255));
      send_byte(head);
      for (int s = SLOT_NOTE; s <= SLOT_PARAM; s++) begin
        if (head[s-1]) send_byte(pick_field(s));
      end
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [10:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_CHANNEL_COUNT) chan_setting = val[6:0];
    else row_setting = val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [10:0] ch_val, input logic [10:0] row_val);
    @(negedge clk);
    write_reg(CFG_CHANNEL_COUNT, ch_val);
    write_reg(CFG_ROW_COUNT, row_val);
    cfg_valid <= 1'b0;
  endtask

  // Waits for every outstanding cell, then covers the result register latency.
  task automatic drain();
    while (cells_due.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic run_phase(input logic [10:0] ch_val, input logic [10:0] row_val,
                           input int n_bytes, input bit squeeze);
    int start;
    drain();
    set_config(ch_val, row_val);
    tx_steady = squeeze || ($urandom_range(0, 3) == 0);
    if (squeeze) hold_req = 1'b1;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_cell();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  always @(posedge clk) begin
    cell_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (cells_due.size() == 0) begin
        $error("cell transaction with no cell outstanding");
        mismatches++;
      end else begin
        want = cells_due.pop_front();
        check_field("note", want.note, out_tdata[6:0]);
        check_field("instrument", want.instrument, out_tdata[14:7]);
        check_field("volume_kind", want.volume_kind, out_tuser[3:0]);
        check_field("volume_value", want.volume_value, out_tdata[21:15]);
        check_field("effect_code", want.effect_code, out_tdata[29:22]);
        check_field("effect_param", want.effect_param, out_tdata[37:30]);
        check_field("has_effect", want.has_effect, out_tuser[4]);
        check_field("row_index", want.row_index, out_tdata[47:38]);
        check_field("channel_index", want.channel_index, out_tdata[54:48]);
        check_field("last_cell", want.last_cell, out_tlast);
      end
    end
  end

  // Result side: random ready patterns, plus one long hold-off on request.
  initial begin
    int          hold;
    int          rx_left;
    logic [31:0] rx_pattern;
    hold = 0;
    rx_left = 0;
    rx_pattern = '1;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          case ($urandom_range(0, 3))
            0: rx_pattern = '1;
            1: rx_pattern = $urandom;
            default: rx_pattern = $urandom | $urandom;
          endcase
          rx_left = $urandom_range(8, 80);
        end
        rx_left--;
        out_tready <= rx_pattern[rx_left % 32];
      end
    end
  end

  initial begin
    #2_000_000;
    $display("xm_pattern_cell_unpacker test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_tdata = '0;
    in_tvalid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_CHANNEL_COUNT;
    cfg_data = '0;
    mismatches = 0;
    bytes_sent = 0;
    burst_left = 0;
    tx_steady = 1'b0;
    hold_req = 1'b0;
    chan_setting = 7'd4;
    row_setting = 11'd64;
    slot = SLOT_HEAD;
    pending_mask = '0;
    cur_note = '0;
    cur_inst = '0;
    cur_vol = '0;
    cur_eff = '0;
    row_pos = '0;
    chan_pos = '0;

    // Empty pack bytes, with and without the unused bits 5 and 6.
    queue_step(8'h80, 1'b1, cell_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_step(8'hE0, 1'b1, cell_of(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    // Unpacked cell: key-off, instrument none, full volume, no effect.
    queue_step(8'h61, 1'b0, '0);
    queue_step(8'hFF, 1'b0, '0);
    queue_step(8'h50, 1'b0, '0);
    queue_step(8'h00, 1'b0, '0);
    queue_step(8'h00, 1'b1,
               cell_of(NOTE_KEY_OFF, 0, VK_VOLUME, 64, 0, 0, 0, 0, 2, 0));
    // Unpacked cell: lowest note, zero volume, all-ones effect.
    queue_step(8'h01, 1'b0, '0);
    queue_step(8'h01, 1'b0, '0);
    queue_step(8'h10, 1'b0, '0);
    queue_step(8'hFF, 1'b0, '0);
    queue_step(8'hFF, 1'b1,
               cell_of(13, 1, VK_VOLUME, 0, 255, 255, 1, 0, 3, 0));
    // Full pack byte: top note, top instrument, full-right panning.
    queue_step(8'h9F, 1'b0, '0);
    queue_step(8'h60, 1'b0, '0);
    queue_step(8'hFE, 1'b0, '0);
    queue_step(8'hCF, 1'b0, '0);
    queue_step(8'h00, 1'b0, '0);
    queue_step(8'h01, 1'b0, '0);
    // Out-of-range note with an unmapped volume and a zero parameter.
    queue_step(8'h95, 1'b0, '0);
    queue_step(8'hFF, 1'b0, '0);
    queue_step(8'h51, 1'b0, '0);
    queue_step(8'h00, 1'b0, '0);
    // Volume command at the top of the range with an effect byte only.
    queue_step(8'h8C, 1'b0, '0);
    queue_step(8'hFF, 1'b0, '0);
    queue_step(8'h80, 1'b0, '0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) send_byte(steps[i].data, steps[i].typed, steps[i].want_cell);
    while (bytes_sent < 175) send_random_cell();
    @(negedge clk);
    in_tvalid <= 1'b0;

    run_phase(11'd1, 11'd1, 120, 1'b1);
    run_phase(11'd0, 11'd0, 80, 1'b0);
    run_phase(11'd3, 11'd2, 150, 1'b0);
    // Channel data above seven bits is dropped; row count above the limit clamps.
    run_phase(11'h7FF, 11'h7FF, 150, 1'b0);
    // Shrinking the channel count leaves the position past the new limit.
    run_phase(11'd5, 11'h400, 100, 1'b0);
    run_phase(11'd2, 11'd3, 150, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("xm_pattern_cell_unpacker test passed");
    end else begin
      $display("xm_pattern_cell_unpacker test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/xmpcu_pkg.sv
hdl/xm_pattern_cell_unpacker.sv
dv/tb_top.sv
